@@ src/oil_pkg.sv @@
// ----------------------------------------------------------------------------
// oil_pkg
// Shared types, constants and character helpers for the operator and integer
// lexer: scan modes, token kinds, error codes and the queue/result records.
// ----------------------------------------------------------------------------
package oil_pkg;

  // Default width of the internal byte position counter
  localparam int unsigned OFFSET_BITS = 24;
  // Depth of the queue between the classifying front and the scanning back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Fixed widths of the result fields
  localparam int unsigned CHAR_W  = 21;
  localparam int unsigned VALUE_W = 63;
  localparam int unsigned KIND_W  = 5;

  typedef logic [23:0]         offs_t;
  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [KIND_W-1:0]   kind_t;

  // Token kinds
  localparam kind_t KIND_UNKNOWN    = 5'd0;
  localparam kind_t KIND_INTEGER    = 5'd1;
  localparam kind_t KIND_PUNCT_BASE = 5'd2;
  localparam kind_t KIND_ASSIGN     = 5'd20;
  localparam kind_t KIND_EQ         = 5'd21;
  localparam kind_t KIND_NEQ        = 5'd22;
  localparam kind_t KIND_GT         = 5'd23;
  localparam kind_t KIND_GTEQ       = 5'd24;
  localparam kind_t KIND_SHR        = 5'd25;
  localparam kind_t KIND_LT         = 5'd26;
  localparam kind_t KIND_LTEQ       = 5'd27;
  localparam kind_t KIND_SHL        = 5'd28;
  localparam kind_t KIND_END        = 5'd29;

  // Character codes
  localparam char_t CH_NUL   = 21'h00;
  localparam char_t CH_BANG  = 21'h21;
  localparam char_t CH_LT    = 21'h3C;
  localparam char_t CH_EQ    = 21'h3D;
  localparam char_t CH_GT    = 21'h3E;
  localparam char_t CH_UNDER = 21'h5F;
  localparam char_t CH_0     = 21'h30;
  localparam char_t CH_9     = 21'h39;
  localparam char_t CH_LA    = 21'h61;
  localparam char_t CH_LF    = 21'h66;
  localparam char_t CH_UA    = 21'h41;
  localparam char_t CH_UF    = 21'h46;
  localparam char_t CH_LB    = 21'h62;
  localparam char_t CH_UB    = 21'h42;
  localparam char_t CH_LO    = 21'h6F;
  localparam char_t CH_UO    = 21'h4F;
  localparam char_t CH_LX    = 21'h78;
  localparam char_t CH_UX    = 21'h58;

  localparam int unsigned NUM_PUNCT = 18;
  // { } [ ] ( ) : , . ; + - * / % & | ~ in token kind order
  localparam char_t PUNCT_CHARS [NUM_PUNCT] = '{
    21'h7B, 21'h7D, 21'h5B, 21'h5D, 21'h28, 21'h29, 21'h3A, 21'h2C, 21'h2E,
    21'h3B, 21'h2B, 21'h2D, 21'h2A, 21'h2F, 21'h25, 21'h26, 21'h7C, 21'h7E
  };

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ZERO,
    MODE_NUMBER,
    MODE_EQ,
    MODE_BANG,
    MODE_GT,
    MODE_LT
  } mode_e;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_BIN,
    BASE_OCT,
    BASE_HEX
  } base_e;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_UNKNOWN,
    ERR_NUMBER
  } err_e;

  // Classified character, front to back
  typedef struct packed {
    char_t       code;      // zero at end of source
    logic [2:0]  bytes;
    logic        eos;
    logic        is_nul;
    logic        is_dec;
    logic        hex_ok;
    logic [3:0]  hex_val;
    base_e       prefix;    // BASE_DEC when not a prefix letter
    logic        is_under;
    logic        is_eq;
    logic        is_bang;
    logic        is_gt;
    logic        is_lt;
    kind_t       punct;     // KIND_UNKNOWN when not punctuation
  } class_t;

  // One result transaction
  typedef struct packed {
    kind_t   kind;
    offs_t   tok_start;
    offs_t   tok_end;
    value_t  value;
    err_e    err;
    offs_t   err_offset;
    char_t   err_char;
    logic    last;
  } res_t;

  // Map a character to its punctuation token kind
  function automatic kind_t punct_kind(char_t c);
    kind_t k;
    k = KIND_UNKNOWN;
    for (int i = 0; i < NUM_PUNCT; i++) begin
      if (c == PUNCT_CHARS[i]) begin
        k = KIND_PUNCT_BASE + KIND_W'(i);
      end
    end
    return k;
  endfunction

endpackage

@@ src/oil_fifo.sv @@
// ----------------------------------------------------------------------------
// oil_fifo
// Small register queue with a full and an empty flag; pop and push may happen
// in the same cycle.
// ----------------------------------------------------------------------------
module oil_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

@@ src/oil_front.sv @@
// ----------------------------------------------------------------------------
// oil_front
// Accepts character transactions, classifies each character and queues the
// classified record for the scanner.
// ----------------------------------------------------------------------------
module oil_front #(
  parameter int unsigned QueueDepth = oil_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [20:0]         char_code_i,
  input  logic [2:0]          char_bytes_i,
  input  logic                end_of_source_i,
  output logic                q_valid_o,
  output oil_pkg::class_t     q_item_o,
  input  logic                q_pop_i
);

  oil_pkg::class_t cls;
  oil_pkg::char_t  c;
  logic            full, empty, push;

  // Classify the incoming character
  always_comb begin
    c            = end_of_source_i ? oil_pkg::CH_NUL : char_code_i;
    cls          = '0;
    cls.code     = c;
    cls.bytes    = char_bytes_i;
    cls.eos      = end_of_source_i;
    cls.is_nul   = (c == oil_pkg::CH_NUL);
    cls.is_dec   = (c >= oil_pkg::CH_0) && (c <= oil_pkg::CH_9);
    cls.is_under = (c == oil_pkg::CH_UNDER);
    cls.is_eq    = (c == oil_pkg::CH_EQ);
    cls.is_bang  = (c == oil_pkg::CH_BANG);
    cls.is_gt    = (c == oil_pkg::CH_GT);
    cls.is_lt    = (c == oil_pkg::CH_LT);
    cls.punct    = oil_pkg::punct_kind(c);
    cls.prefix   = oil_pkg::BASE_DEC;
    if (c == oil_pkg::CH_LB || c == oil_pkg::CH_UB) begin
      cls.prefix = oil_pkg::BASE_BIN;
    end else if (c == oil_pkg::CH_LO || c == oil_pkg::CH_UO) begin
      cls.prefix = oil_pkg::BASE_OCT;
    end else if (c == oil_pkg::CH_LX || c == oil_pkg::CH_UX) begin
      cls.prefix = oil_pkg::BASE_HEX;
    end
    cls.hex_ok  = 1'b0;
    cls.hex_val = '0;
    if (cls.is_dec) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(c - oil_pkg::CH_0);
    end else if (c >= oil_pkg::CH_LA && c <= oil_pkg::CH_LF) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(c - oil_pkg::CH_LA + 21'd10);
    end else if (c >= oil_pkg::CH_UA && c <= oil_pkg::CH_UF) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(c - oil_pkg::CH_UA + 21'd10);
    end
  end

  assign push       = in_valid_i && !full;
  assign in_stall_o = full;
  assign q_valid_o  = !empty;

  oil_fifo #(
    .Width ($bits(oil_pkg::class_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls),
    .full_o  (full),
    .pop_i   (q_pop_i),
    .rdata_o (q_item_o),
    .empty_o (empty)
  );

endmodule

@@ src/oil_back.sv @@
// ----------------------------------------------------------------------------
// oil_back
// Scanner: takes classified characters from the queue, runs the token state
// machine and number accumulator, and presents up to two result transactions
// per character through an output register with one spare slot.
// ----------------------------------------------------------------------------
module oil_back #(
  parameter int unsigned OffsetBits = oil_pkg::OFFSET_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  oil_pkg::class_t  item_i,
  output logic             item_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output oil_pkg::res_t    res_o
);

  typedef logic [OffsetBits-1:0] pos_t;

  oil_pkg::mode_e  mode_q, mode_d;
  pos_t            pos_q, pos_d;
  pos_t            pend_q, pend_d;
  oil_pkg::value_t val_q, val_d;
  oil_pkg::base_e  base_q, base_d;
  logic            body_q, body_d;
  logic            ovf_q, ovf_d;
  pos_t            ovf_off_q, ovf_off_d;
  oil_pkg::char_t  ovf_chr_q, ovf_chr_d;

  oil_pkg::res_t   out_q, spare_q;
  logic            out_v_q, spare_v_q;

  oil_pkg::res_t   ra, rb, r0, r1;
  logic            ra_v, rb_v, r0_v, r1_v;
  logic            done;
  pos_t            pos_adv;
  logic            digit_ok;
  logic [66:0]     scaled, sum;
  logic            over;
  logic            out_pop, can_load;

  assign pos_adv = pos_q + OffsetBits'(item_i.bytes);

  // Digit range for the current base
  always_comb begin
    unique case (base_q)
      oil_pkg::BASE_DEC: digit_ok = item_i.hex_val < 4'd10;
      oil_pkg::BASE_BIN: digit_ok = item_i.hex_val < 4'd2;
      oil_pkg::BASE_OCT: digit_ok = item_i.hex_val < 4'd8;
      default:           digit_ok = 1'b1;
    endcase
    digit_ok = digit_ok && item_i.hex_ok && !item_i.eos;
  end

  // Scale the value by the base with shifts and check against the signed max
  always_comb begin
    unique case (base_q)
      oil_pkg::BASE_DEC: scaled = ({4'b0, val_q} << 3) + ({4'b0, val_q} << 1);
      oil_pkg::BASE_BIN: scaled = {4'b0, val_q} << 1;
      oil_pkg::BASE_OCT: scaled = {4'b0, val_q} << 3;
      default:           scaled = {4'b0, val_q} << 4;
    endcase
    sum  = scaled + 67'(item_i.hex_val);
    over = |sum[66:63];
  end

  // Token state machine: pending token first, then the new character
  always_comb begin
    mode_d    = oil_pkg::MODE_IDLE;
    pos_d     = pos_q;
    pend_d    = pend_q;
    val_d     = val_q;
    base_d    = base_q;
    body_d    = body_q;
    ovf_d     = ovf_q;
    ovf_off_d = ovf_off_q;
    ovf_chr_d = ovf_chr_q;
    ra        = '0;
    rb        = '0;
    ra_v      = 1'b0;
    rb_v      = 1'b0;
    done      = 1'b0;

    unique case (mode_q)
      oil_pkg::MODE_ZERO, oil_pkg::MODE_NUMBER: begin
        if (mode_q == oil_pkg::MODE_ZERO && !item_i.eos &&
            item_i.prefix != oil_pkg::BASE_DEC) begin
          base_d = item_i.prefix;
          val_d  = '0;
          body_d = 1'b0;
          pos_d  = pos_adv;
          mode_d = oil_pkg::MODE_NUMBER;
          done   = 1'b1;
        end else if (!item_i.eos && item_i.is_under) begin
          body_d = 1'b1;
          pos_d  = pos_adv;
          mode_d = oil_pkg::MODE_NUMBER;
          done   = 1'b1;
        end else if (digit_ok) begin
          body_d = 1'b1;
          if (!ovf_q) begin
            if (over) begin
              ovf_d     = 1'b1;
              ovf_off_d = pos_q;
              ovf_chr_d = item_i.code;
            end else begin
              val_d = sum[62:0];
            end
          end
          pos_d  = pos_adv;
          mode_d = oil_pkg::MODE_NUMBER;
          done   = 1'b1;
        end else begin
          // Close the literal
          ra_v         = 1'b1;
          ra.kind      = oil_pkg::KIND_INTEGER;
          ra.tok_start = oil_pkg::offs_t'(pend_q);
          ra.tok_end   = oil_pkg::offs_t'(pos_q);
          ra.value     = val_q;
          if (ovf_q) begin
            ra.err        = oil_pkg::ERR_NUMBER;
            ra.err_offset = oil_pkg::offs_t'(ovf_off_q);
            ra.err_char   = ovf_chr_q;
          end else if (!body_q) begin
            ra.err        = oil_pkg::ERR_NUMBER;
            ra.err_offset = oil_pkg::offs_t'(pos_q);
            ra.err_char   = item_i.code;
          end
        end
      end
      oil_pkg::MODE_EQ, oil_pkg::MODE_BANG, oil_pkg::MODE_GT, oil_pkg::MODE_LT: begin
        ra_v         = 1'b1;
        ra.tok_start = oil_pkg::offs_t'(pend_q);
        if (item_i.is_eq) begin
          done = 1'b1;
          unique case (mode_q)
            oil_pkg::MODE_EQ:   ra.kind = oil_pkg::KIND_EQ;
            oil_pkg::MODE_BANG: ra.kind = oil_pkg::KIND_NEQ;
            oil_pkg::MODE_GT:   ra.kind = oil_pkg::KIND_GTEQ;
            default:            ra.kind = oil_pkg::KIND_LTEQ;
          endcase
        end else if (mode_q == oil_pkg::MODE_GT && item_i.is_gt) begin
          done    = 1'b1;
          ra.kind = oil_pkg::KIND_SHR;
        end else if (mode_q == oil_pkg::MODE_LT && item_i.is_lt) begin
          done    = 1'b1;
          ra.kind = oil_pkg::KIND_SHL;
        end else begin
          unique case (mode_q)
            oil_pkg::MODE_EQ:   ra.kind = oil_pkg::KIND_ASSIGN;
            oil_pkg::MODE_BANG: ra.kind = oil_pkg::KIND_UNKNOWN;
            oil_pkg::MODE_GT:   ra.kind = oil_pkg::KIND_GT;
            default:            ra.kind = oil_pkg::KIND_LT;
          endcase
        end
        if (done) begin
          pos_d      = pos_adv;
          ra.tok_end = oil_pkg::offs_t'(pos_adv);
        end else begin
          ra.tok_end = oil_pkg::offs_t'(pos_q);
        end
        if (mode_q == oil_pkg::MODE_BANG && !done) begin
          ra.err        = oil_pkg::ERR_UNKNOWN;
          ra.err_offset = oil_pkg::offs_t'(pend_q);
          ra.err_char   = oil_pkg::CH_BANG;
        end
      end
      default: begin
      end
    endcase

    // Start a new token from this character
    if (!done) begin
      rb.tok_start = oil_pkg::offs_t'(pos_q);
      rb.tok_end   = oil_pkg::offs_t'(pos_q);
      if (item_i.eos) begin
        rb_v    = 1'b1;
        rb.kind = oil_pkg::KIND_END;
      end else begin
        pos_d  = pos_adv;
        pend_d = pos_q;
        if (item_i.is_nul) begin
          rb_v    = 1'b1;
          rb.kind = oil_pkg::KIND_END;
        end else if (item_i.is_dec) begin
          val_d     = oil_pkg::value_t'(item_i.hex_val);
          base_d    = oil_pkg::BASE_DEC;
          body_d    = 1'b1;
          ovf_d     = 1'b0;
          ovf_off_d = '0;
          ovf_chr_d = '0;
          mode_d    = (item_i.hex_val == 4'd0) ? oil_pkg::MODE_ZERO : oil_pkg::MODE_NUMBER;
        end else if (item_i.is_eq) begin
          mode_d = oil_pkg::MODE_EQ;
        end else if (item_i.is_bang) begin
          mode_d = oil_pkg::MODE_BANG;
        end else if (item_i.is_gt) begin
          mode_d = oil_pkg::MODE_GT;
        end else if (item_i.is_lt) begin
          mode_d = oil_pkg::MODE_LT;
        end else begin
          rb_v       = 1'b1;
          rb.kind    = item_i.punct;
          rb.tok_end = oil_pkg::offs_t'(pos_adv);
          if (item_i.punct == oil_pkg::KIND_UNKNOWN) begin
            rb.err        = oil_pkg::ERR_UNKNOWN;
            rb.err_offset = oil_pkg::offs_t'(pos_q);
            rb.err_char   = item_i.code;
          end
        end
      end
    end

    // Order the results and mark the last one
    r0   = ra_v ? ra : rb;
    r0_v = ra_v || rb_v;
    r1   = rb;
    r1_v = ra_v && rb_v;
    r0.last = !r1_v;
    r1.last = 1'b1;
  end

  // Output register with one spare slot
  assign out_pop     = out_v_q && !out_stall_i;
  assign can_load    = !spare_v_q && (!out_v_q || out_pop);
  assign item_pop_o  = item_valid_i && can_load;
  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= oil_pkg::MODE_IDLE;
      pos_q     <= '0;
      pend_q    <= '0;
      val_q     <= '0;
      base_q    <= oil_pkg::BASE_DEC;
      body_q    <= 1'b0;
      ovf_q     <= 1'b0;
      ovf_off_q <= '0;
      ovf_chr_q <= '0;
    end else if (item_pop_o) begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      pend_q    <= pend_d;
      val_q     <= val_d;
      base_q    <= base_d;
      body_q    <= body_d;
      ovf_q     <= ovf_d;
      ovf_off_q <= ovf_off_d;
      ovf_chr_q <= ovf_chr_d;
    end
  end

  // Hold, advance or load the result slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (item_pop_o) begin
      out_v_q   <= r0_v;
      spare_v_q <= r1_v;
    end else if (out_pop) begin
      out_v_q   <= spare_v_q;
      spare_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      out_q   <= r0;
      spare_q <= r1;
    end else if (out_pop) begin
      out_q   <= spare_q;
    end
  end

  a_spare_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q |-> out_v_q)
    else $error("spare result without head result");

  a_pos_only_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_pop_o |=> $stable(pos_q))
    else $error("position moved without a transaction");

  a_ovf_in_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> ($past(mode_q) == oil_pkg::MODE_NUMBER ||
                      $past(mode_q) == oil_pkg::MODE_ZERO))
    else $error("overflow flagged outside a literal");

endmodule

@@ src/operator_and_integer_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// operator_and_integer_lexer_unit
// Operator and integer lexer: one decoded character per input transaction,
// tokens with byte offsets, integer values and error details out.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  input   | in_valid_i / in_stall_o | char_code, char_bytes, end_of_source
//  output  | out_valid_o/out_stall_i | token fields, error fields, last_of_run
//
//  A character is taken once the output slots can hold its results; one that
//  closes a pending token and gives a second holds the next one back until
//  the spare slot drains. Input passes the queue, then the output register.
//  Reset clears the scan state, the position and both queues at once.
//  A stalled output holds the result register (and the spare slot after a
//  character that gave two tokens); characters then back up in the input
//  queue, and in_stall_o rises once it is full.
// ----------------------------------------------------------------------------
module operator_and_integer_lexer_unit #(
  parameter int unsigned OffsetBits = oil_pkg::OFFSET_BITS,
  parameter int unsigned QueueDepth = oil_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [20:0] char_code_i,
  input  logic [2:0]  char_bytes_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [23:0] token_start_o,
  output logic [23:0] token_end_o,
  output logic [62:0] int_value_o,
  output logic [1:0]  error_kind_o,
  output logic [23:0] error_offset_o,
  output logic [20:0] error_char_o,
  output logic        last_of_run_o
);

  oil_pkg::class_t q_item;
  logic            q_valid, q_pop;
  oil_pkg::res_t   res;

  oil_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .char_bytes_i    (char_bytes_i),
    .end_of_source_i (end_of_source_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  oil_back #(
    .OffsetBits (OffsetBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  // Unpack the result transaction
  assign token_kind_o   = res.kind;
  assign token_start_o  = res.tok_start;
  assign token_end_o    = res.tok_end;
  assign int_value_o    = res.value;
  assign error_kind_o   = res.err;
  assign error_offset_o = res.err_offset;
  assign error_char_o   = res.err_char;
  assign last_of_run_o  = res.last;

endmodule

@@ test/tb_operator_and_integer_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_operator_and_integer_lexer_unit
// Self-checking bench for the operator and integer lexer. A short directed
// source covers every two-character operator, the lone bang, an empty prefix
// and the extremes of the character fields. A random source follows: mostly
// well-formed numbers and operators, with noise, NUL and end-of-source items.
// A scoreboard tracks the scan state, predicts each token and checks every
// field of every output transaction in order.
// ----------------------------------------------------------------------------
module tb_operator_and_integer_lexer_unit;
  import oil_pkg::*;

  localparam longint unsigned VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned RANDOM_CHARS = 600;

  typedef struct packed {
    char_t      code;
    logic [2:0] nbytes;
    logic       eos;
  } src_char_t;

  // Token predictor and in-order checker
  class lex_scoreboard;
    res_t   token_q[$];
    int     errors;
    int     chars_seen;
    int     tokens_checked;
    int     flagged_tokens;
    int     int_tokens;
    mode_e  mode;
    offs_t  pos;
    offs_t  tok_start;
    value_t num;
    base_e  base;
    bit     body;
    bit     ovf;
    offs_t  ovf_off;
    char_t  ovf_chr;

    function new();
      mode      = MODE_IDLE;
      pos       = '0;
      tok_start = '0;
      num       = '0;
      base      = BASE_DEC;
      body      = 1'b0;
      ovf       = 1'b0;
      ovf_off   = '0;
      ovf_chr   = '0;
    endfunction

    function void add_token(kind_t k, offs_t s, offs_t e, value_t v, err_e er,
                            offs_t eo, char_t ec);
      res_t r;
      r.kind       = k;
      r.tok_start  = s;
      r.tok_end    = e;
      r.value      = v;
      r.err        = er;
      r.err_offset = eo;
      r.err_char   = ec;
      r.last       = 1'b0;
      token_q.push_back(r);
    endfunction

    // Advance the scan state by one accepted character and queue its tokens
    function void note_char(char_t code, logic [2:0] nbytes, logic eos);
      char_t           c;
      mode_e           was;
      int              dig;
      longint unsigned dv;
      longint unsigned radix;
      base_e           pfx;
      kind_t           k;
      bit              took;
      int              first;
      offs_t           here;
      res_t            tail;
      chars_seen++;
      first = token_q.size();
      c     = eos ? CH_NUL : code;
      was   = mode;
      mode  = MODE_IDLE;
      took  = 1'b0;
      dig   = -1;
      if (!eos) begin
        if (c >= CH_0 && c <= CH_9) dig = int'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF) dig = int'(c - CH_LA) + 10;
        else if (c >= CH_UA && c <= CH_UF) dig = int'(c - CH_UA) + 10;
      end
      pfx = BASE_DEC;
      if (c == CH_LB || c == CH_UB) pfx = BASE_BIN;
      else if (c == CH_LO || c == CH_UO) pfx = BASE_OCT;
      else if (c == CH_LX || c == CH_UX) pfx = BASE_HEX;

      if (was == MODE_ZERO && pfx != BASE_DEC) begin
        // Prefix letter: restart the value in the new base
        base = pfx;
        num  = '0;
        body = 1'b0;
        pos  = pos + offs_t'(nbytes);
        mode = MODE_NUMBER;
        took = 1'b1;
      end else if (was == MODE_ZERO || was == MODE_NUMBER) begin
        radix = (base == BASE_DEC) ? 10 : (base == BASE_BIN) ? 2 :
                (base == BASE_OCT) ? 8 : 16;
        if (!eos && c == CH_UNDER) begin
          body = 1'b1;
          pos  = pos + offs_t'(nbytes);
          mode = MODE_NUMBER;
          took = 1'b1;
        end else if (dig >= 0 && longint'(dig) < radix) begin
          // Grow the value unless it would pass the signed 64-bit maximum
          dv   = longint'(dig);
          body = 1'b1;
          if (!ovf) begin
            if (num > (VALUE_MAX - dv) / radix) begin
              ovf     = 1'b1;
              ovf_off = pos;
              ovf_chr = c;
            end else begin
              num = value_t'(num * radix + dv);
            end
          end
          pos  = pos + offs_t'(nbytes);
          mode = MODE_NUMBER;
          took = 1'b1;
        end else if (ovf) begin
          add_token(KIND_INTEGER, tok_start, pos, num, ERR_NUMBER, ovf_off, ovf_chr);
        end else if (!body) begin
          add_token(KIND_INTEGER, tok_start, pos, num, ERR_NUMBER, pos, c);
        end else begin
          add_token(KIND_INTEGER, tok_start, pos, num, ERR_OK, '0, '0);
        end
      end else if (was != MODE_IDLE) begin
        // Resolve the pending operator with this character as lookahead
        if (c == CH_EQ) begin
          k = (was == MODE_EQ) ? KIND_EQ : (was == MODE_BANG) ? KIND_NEQ :
              (was == MODE_GT) ? KIND_GTEQ : KIND_LTEQ;
          took = 1'b1;
        end else if (was == MODE_GT && c == CH_GT) begin
          k    = KIND_SHR;
          took = 1'b1;
        end else if (was == MODE_LT && c == CH_LT) begin
          k    = KIND_SHL;
          took = 1'b1;
        end else begin
          k = (was == MODE_EQ) ? KIND_ASSIGN : (was == MODE_BANG) ? KIND_UNKNOWN :
              (was == MODE_GT) ? KIND_GT : KIND_LT;
        end
        if (took) pos = pos + offs_t'(nbytes);
        if (k == KIND_UNKNOWN) begin
          add_token(k, tok_start, pos, '0, ERR_UNKNOWN, tok_start, CH_BANG);
        end else begin
          add_token(k, tok_start, pos, '0, ERR_OK, '0, '0);
        end
      end

      // Start a new token with this character
      if (!took) begin
        here = pos;
        if (eos) begin
          add_token(KIND_END, here, here, '0, ERR_OK, '0, '0);
        end else begin
          pos       = pos + offs_t'(nbytes);
          tok_start = here;
          if (c == CH_NUL) begin
            add_token(KIND_END, here, here, '0, ERR_OK, '0, '0);
          end else if (c >= CH_0 && c <= CH_9) begin
            num     = value_t'(c - CH_0);
            base    = BASE_DEC;
            body    = 1'b1;
            ovf     = 1'b0;
            ovf_off = '0;
            ovf_chr = '0;
            mode    = (c == CH_0) ? MODE_ZERO : MODE_NUMBER;
          end else if (c == CH_EQ) begin
            mode = MODE_EQ;
          end else if (c == CH_BANG) begin
            mode = MODE_BANG;
          end else if (c == CH_GT) begin
            mode = MODE_GT;
          end else if (c == CH_LT) begin
            mode = MODE_LT;
          end else begin
            k = KIND_UNKNOWN;
            for (int i = 0; i < NUM_PUNCT; i++) begin
              if (c == PUNCT_CHARS[i]) k = KIND_PUNCT_BASE + kind_t'(i);
            end
            if (k == KIND_UNKNOWN) begin
              add_token(k, here, pos, '0, ERR_UNKNOWN, here, c);
            end else begin
              add_token(k, here, pos, '0, ERR_OK, '0, '0);
            end
          end
        end
      end

      // Mark the final token of this character
      if (token_q.size() > first) begin
        tail      = token_q.pop_back();
        tail.last = 1'b1;
        token_q.push_back(tail);
      end
    endfunction

    function void cmp_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      end
    endfunction

    // Check one output transaction against the oldest predicted token
    function void check_token(res_t got);
      res_t want;
      tokens_checked++;
      if (got.err != ERR_OK) flagged_tokens++;
      if (got.kind == KIND_INTEGER) int_tokens++;
      if (token_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, expected none, actual kind %0d", $time,
                 got.kind);
      end else begin
        want = token_q.pop_front();
        cmp_field("token_kind", want.kind, got.kind);
        cmp_field("token_start", want.tok_start, got.tok_start);
        cmp_field("token_end", want.tok_end, got.tok_end);
        cmp_field("int_value", want.value, got.value);
        cmp_field("error_kind", want.err, got.err);
        cmp_field("error_offset", want.err_offset, got.err_offset);
        cmp_field("error_char", want.err_char, got.err_char);
        cmp_field("last_of_run", want.last, got.last);
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [20:0] char_code_i     = '0;
  logic [2:0]  char_bytes_i    = 3'd1;
  logic        end_of_source_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [4:0]  token_kind_o;
  logic [23:0] token_start_o;
  logic [23:0] token_end_o;
  logic [62:0] int_value_o;
  logic [1:0]  error_kind_o;
  logic [23:0] error_offset_o;
  logic [20:0] error_char_o;
  logic        last_of_run_o;

  lex_scoreboard sb = new();
  src_char_t     source_q[$];

  always #2 clk_i = ~clk_i;

  operator_and_integer_lexer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .char_bytes_i   (char_bytes_i),
    .end_of_source_i(end_of_source_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_end_o    (token_end_o),
    .int_value_o    (int_value_o),
    .error_kind_o   (error_kind_o),
    .error_offset_o (error_offset_o),
    .error_char_o   (error_char_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Stretches with no idling on either side
  function automatic bit calm_phase();
    return (sb.chars_seen >= 100 && sb.chars_seen < 160) ||
           (sb.chars_seen >= 420 && sb.chars_seen < 470);
  endfunction

  function automatic void put_item(char_t code, logic [2:0] nbytes, logic eos);
    src_char_t it;
    it.code   = code;
    it.nbytes = nbytes;
    it.eos    = eos;
    source_q.push_back(it);
  endfunction

  // Mostly one byte, some multi-byte, a few odd sizes
  function automatic void put_char(char_t code);
    int unsigned r;
    logic [2:0]  nb;
    r  = $urandom_range(0, 99);
    nb = (r < 70) ? 3'd1 : (r < 94) ? 3'($urandom_range(2, 4)) : 3'($urandom_range(0, 7));
    put_item(code, nb, 1'b0);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_item(char_t'(s[i]), 3'd1, 1'b0);
  endfunction

  // Build the random source: well-formed runs with random content plus noise
  task automatic build_random_source(int target);
    int unsigned pick;
    base_e       b;
    int          radix;
    int          len;
    int          v;
    bit          up;
    char_t       op;
    while (source_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Integer literal, sometimes long enough to overflow
        b     = base_e'($urandom_range(0, 3));
        radix = (b == BASE_DEC) ? 10 : (b == BASE_BIN) ? 2 : (b == BASE_OCT) ? 8 : 16;
        if ($urandom_range(0, 9) == 0) begin
          len = ((b == BASE_BIN) ? 64 : (b == BASE_OCT) ? 21 : (b == BASE_DEC) ? 19 : 16)
                + $urandom_range(0, 3);
        end else begin
          len = $urandom_range(0, 6);
        end
        up = $urandom_range(0, 1);
        if (b == BASE_DEC) begin
          put_char(CH_0 + char_t'($urandom_range(0, 9)));
        end else begin
          put_char(CH_0);
          case (b)
            BASE_BIN: put_char(up ? CH_UB : CH_LB);
            BASE_OCT: put_char(up ? CH_UO : CH_LO);
            default:  put_char(up ? CH_UX : CH_LX);
          endcase
        end
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 6) == 0) begin
            put_char(CH_UNDER);
          end else begin
            v = $urandom_range(0, radix - 1);
            if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 15);
            if (v < 10) put_char(CH_0 + char_t'(v));
            else put_char(($urandom_range(0, 1) ? CH_LA : CH_UA) + char_t'(v - 10));
          end
        end
      end else if (pick < 42) begin
        // Value right at the limit, then maybe a digit or two too many
        if ($urandom_range(0, 1)) put_text("9223372036854775807");
        else put_text("0x7fff_ffff_ffff_ffff");
        repeat ($urandom_range(0, 2)) put_char(CH_0 + char_t'($urandom_range(0, 9)));
      end else if (pick < 67) begin
        // Operator, often completed to its two-character form
        case ($urandom_range(0, 3))
          0:       op = CH_EQ;
          1:       op = CH_BANG;
          2:       op = CH_GT;
          default: op = CH_LT;
        endcase
        put_char(op);
        case ($urandom_range(0, 3))
          0:       put_char(CH_EQ);
          1:       put_char(op);
          default: ;
        endcase
      end else if (pick < 82) begin
        put_char(PUNCT_CHARS[$urandom_range(0, NUM_PUNCT - 1)]);
      end else if (pick < 92) begin
        if ($urandom_range(0, 1)) put_char(char_t'($urandom_range(0, 21'h1FFFFF)));
        else put_char(char_t'($urandom_range(21'h20, 21'h7E)));
      end else if (pick < 96) begin
        put_char(CH_NUL);
      end else begin
        put_item(char_t'($urandom_range(0, 21'h1FFFFF)), 3'($urandom_range(0, 7)), 1'b1);
      end
    end
  endtask

  // Offer each character, holding it until the block takes it
  task automatic feed_source();
    src_char_t it;
    int        gap;
    while (source_q.size() > 0) begin
      it  = source_q.pop_front();
      gap = calm_phase() ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i      <= 1'b1;
      char_code_i     <= it.code;
      char_bytes_i    <= it.nbytes;
      end_of_source_i <= it.eos;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  // Note every accepted input transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_char(char_code_i, char_bytes_i, end_of_source_i);
    end
  end

  // Check every accepted output transaction
  always @(posedge clk_i) begin : token_monitor
    res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind       = token_kind_o;
      got.tok_start  = token_start_o;
      got.tok_end    = token_end_o;
      got.value      = int_value_o;
      got.err        = err_e'(error_kind_o);
      got.err_offset = error_offset_o;
      got.err_char   = error_char_o;
      got.last       = last_of_run_o;
      sb.check_token(got);
    end
  end

  // Stall the output at random; hold off once for long enough to back up the input
  initial begin : drain_side
    int n;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && sb.chars_seen >= 300) begin
        held = 1'b1;
        n    = 150;
      end else begin
        n = calm_phase() ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : run_test
    int directed;
    // Every two-character operator, assign, lone bang, lt and gt
    put_text("==!=>=>><=<<=!<>");
    // Binary prefix with a digit outside its base, then punctuation
    put_text("0b2{~");
    // Widest code point and byte count, zero-byte NUL
    put_item(21'h1FFFFF, 3'd7, 1'b0);
    put_item(CH_NUL, 3'd0, 1'b0);
    // Hex prefix cut off by end of source
    put_text("0x");
    put_item(21'h155555, 3'd5, 1'b1);
    directed = source_q.size();
    build_random_source(directed + RANDOM_CHARS);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    feed_source();

    // Drain outstanding tokens, then allow for the pipeline latency
    while (sb.token_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Scanned %0d characters (%0d directed), checked %0d tokens",
             sb.chars_seen, directed, sb.tokens_checked);
    $display("of which %0d integers and %0d carried an error flag",
             sb.int_tokens, sb.flagged_tokens);
    if (sb.errors == 0 && sb.token_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ operator_and_integer_lexer_unit.f @@
src/oil_pkg.sv
src/oil_fifo.sv
src/oil_front.sv
src/oil_back.sv
src/operator_and_integer_lexer_unit.sv
test/tb_operator_and_integer_lexer_unit.sv
